// ===== rtl/kec_pkg.sv =====
package kec_pkg;

    localparam int unsigned TABLE_ENTRIES_DEF = 4096;
    localparam int unsigned MAX_PROBES_DEF    = 8;
    localparam logic [63:0] HASH_MULT         = 64'd2654435761;
    localparam logic [31:0] COUNT_MAX         = 32'hFFFF_FFFF;
    localparam logic [5:0]  KMER_LENGTH_RST   = 6'd21;
    localparam logic [15:0] MIN_WEIGHT_RST    = 16'd3;

    localparam logic [0:0] REG_KMER_LENGTH = 1'b0;
    localparam logic [0:0] REG_MIN_WEIGHT  = 1'b1;

    localparam logic KIND_BASE   = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic clear;      // clear one slot valid bit after reset
        logic load;       // capture request, update rolling k-mer
        logic mult_lo;    // first partial product
        logic mult_hi;    // high partial product, form home slot
        logic probe_rd;   // issue read at current probe slot
        logic probe_nxt;  // advance probe index
        logic wr_hit;     // write incremented count
        logic wr_new;     // write fresh entry
        logic emit;       // present result
        logic set_over;   // mark overflow on result
    } kec_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic clear_last;
        logic is_lookup;
        logic counted;    // enough bases for a k-mer
        logic slot_valid;
        logic key_match;
        logic last_probe;
        logic table_full;
    } kec_stat_t;

    function automatic logic [1:0] base_code(input logic [7:0] ch);
        logic [1:0] c;
        c = 2'd0;
        case (ch)
            8'h43, 8'h63: c = 2'd1;
            8'h47, 8'h67: c = 2'd2;
            8'h54, 8'h74: c = 2'd3;
            default:      c = 2'd0;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/kec_ctrl.sv =====
module kec_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  kec_pkg::kec_stat_t stat,
    output kec_pkg::kec_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_MUL_LO, S_MUL_HI, S_READ, S_CHECK, S_DONE
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (stat.clear_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    state_next = S_MUL_LO;
                end
            end
            S_MUL_LO:
            begin
                if (!stat.is_lookup && !stat.counted)
                    state_next = S_IDLE;
                else
                begin
                    cmd.mult_lo = 1'b1;
                    state_next = S_MUL_HI;
                end
            end
            S_MUL_HI:
            begin
                cmd.mult_hi = 1'b1;
                state_next = S_READ;
            end
            S_READ:
            begin
                cmd.probe_rd = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (stat.slot_valid && stat.key_match)
                begin
                    cmd.wr_hit = !stat.is_lookup;
                    cmd.emit = 1'b1;
                    state_next = S_DONE;
                end
                else if (!stat.slot_valid)
                begin
                    if (!stat.is_lookup && !stat.table_full)
                        cmd.wr_new = 1'b1;
                    else if (!stat.is_lookup)
                        cmd.set_over = 1'b1;
                    cmd.emit = 1'b1;
                    state_next = S_DONE;
                end
                else if (stat.last_probe)
                begin
                    cmd.set_over = !stat.is_lookup;
                    cmd.emit = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.probe_nxt = 1'b1;
                    state_next = S_READ;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_CLEAR;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// ===== rtl/kec_datapath.sv =====
module kec_datapath
#(
    parameter int unsigned TABLE_ENTRIES = kec_pkg::TABLE_ENTRIES_DEF,
    parameter int unsigned MAX_PROBES    = kec_pkg::MAX_PROBES_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  kec_pkg::kec_cmd_t  cmd,
    output kec_pkg::kec_stat_t stat,
    input  logic               cfg_we,
    input  logic [0:0]         cfg_idx,
    input  logic [15:0]        cfg_data,
    input  logic               kind,
    input  logic               first_of_read,
    input  logic [7:0]         base_char,
    input  logic [63:0]        query_kmer,
    output logic               result_valid,
    output logic               result_kind,
    output logic [63:0]        kmer_value,
    output logic [31:0]        edge_count,
    output logic               newly_added,
    output logic               meets_min_weight,
    output logic               table_overflow
);

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int PW = (MAX_PROBES > 1) ? $clog2(MAX_PROBES) : 1;
    localparam logic [AW:0] FULL = AW'(0) | (AW+1)'(TABLE_ENTRIES);

    logic [5:0]  klen_reg;
    logic [15:0] minw_reg;
    logic [63:0] roll_reg;
    logic [5:0]  seen_reg;
    logic [63:0] key_reg;
    logic        lookup_reg;
    logic        counted_reg;
    logic [63:0] plo_reg;
    logic [AW-1:0] slot_reg;
    logic [PW-1:0] probe_reg;
    logic [AW:0]   used_reg;
    logic [AW-1:0] clr_reg;
    logic        mem_vld [TABLE_ENTRIES];
    logic [63:0] mem_key [TABLE_ENTRIES];
    logic [31:0] mem_cnt [TABLE_ENTRIES];
    logic [63:0] rd_key_reg;
    logic [31:0] rd_cnt_reg;
    logic        rd_valid_reg;

    logic [5:0]  k_eff;
    logic [63:0] kmask;
    logic [63:0] roll_next;
    logic [5:0]  seen_next;
    logic [63:0] h_full;
    logic [63:0] h_mix;
    logic [31:0] cnt_inc;
    logic [31:0] res_cnt;

    always_comb
    begin
        if (klen_reg < 6'd2)
            k_eff = 6'd2;
        else if (klen_reg > 6'd32)
            k_eff = 6'd32;
        else
            k_eff = klen_reg;
        if (k_eff == 6'd32)
            kmask = '1;
        else
            kmask = (64'd1 << {k_eff[4:0], 1'b0}) - 64'd1;
        roll_next = first_of_read ? 64'd0 : roll_reg;
        seen_next = first_of_read ? 6'd0 : seen_reg;
        roll_next = ((roll_next << 2) | {62'd0, kec_pkg::base_code(base_char)}) & kmask;
        if (seen_next < 6'd32)
            seen_next = seen_next + 6'd1;
    end

    // 64x32 multiply split into a low and a high partial product
    assign h_full = plo_reg + ({32'd0, key_reg[63:32]} * kec_pkg::HASH_MULT << 32);
    assign h_mix  = h_full ^ {32'd0, h_full[63:32]};
    assign cnt_inc = (rd_cnt_reg == kec_pkg::COUNT_MAX) ? rd_cnt_reg : rd_cnt_reg + 32'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            klen_reg <= kec_pkg::KMER_LENGTH_RST;
            minw_reg <= kec_pkg::MIN_WEIGHT_RST;
            roll_reg <= '0;
            seen_reg <= '0;
            used_reg <= '0;
            clr_reg <= '0;
            result_valid <= 1'b0;
        end
        else
        begin
            result_valid <= cmd.emit;
            if (cmd.clear)
                clr_reg <= clr_reg + 1'b1;
            if (cfg_we)
            begin
                unique case (cfg_idx)
                    kec_pkg::REG_KMER_LENGTH: klen_reg <= cfg_data[5:0];
                    kec_pkg::REG_MIN_WEIGHT:  minw_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.load && kind == kec_pkg::KIND_BASE)
            begin
                roll_reg <= roll_next;
                seen_reg <= seen_next;
            end
            if (cmd.wr_new)
                used_reg <= used_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            lookup_reg  <= kind;
            key_reg     <= (kind == kec_pkg::KIND_LOOKUP) ? query_kmer : roll_next;
            counted_reg <= (seen_next >= k_eff);
        end
        if (cmd.mult_lo)
            plo_reg <= {32'd0, key_reg[31:0]} * kec_pkg::HASH_MULT;
        if (cmd.mult_hi)
        begin
            slot_reg  <= h_mix[AW-1:0];
            probe_reg <= '0;
        end
        if (cmd.probe_nxt)
        begin
            slot_reg  <= slot_reg + 1'b1;
            probe_reg <= probe_reg + 1'b1;
        end
        if (cmd.probe_rd)
        begin
            rd_key_reg   <= mem_key[slot_reg];
            rd_cnt_reg   <= mem_cnt[slot_reg];
            rd_valid_reg <= mem_vld[slot_reg];
        end
        if (cmd.clear)
            mem_vld[clr_reg] <= 1'b0;
        else if (cmd.wr_new)
            mem_vld[slot_reg] <= 1'b1;
        if (cmd.wr_new)
        begin
            mem_key[slot_reg] <= key_reg;
            mem_cnt[slot_reg] <= 32'd1;
        end
        else if (cmd.wr_hit)
            mem_cnt[slot_reg] <= cnt_inc;
        if (cmd.emit)
        begin
            result_kind      <= lookup_reg;
            kmer_value       <= key_reg;
            edge_count       <= res_cnt;
            newly_added      <= cmd.wr_new;
            meets_min_weight <= (res_cnt >= {16'd0, minw_reg});
            table_overflow   <= cmd.set_over;
        end
    end

    always_comb
    begin
        if (cmd.wr_new)
            res_cnt = 32'd1;
        else if (rd_valid_reg && rd_key_reg == key_reg)
            res_cnt = lookup_reg ? rd_cnt_reg : cnt_inc;
        else
            res_cnt = 32'd0;
    end

    assign stat.clear_last = (clr_reg == AW'(TABLE_ENTRIES - 1));
    assign stat.is_lookup  = lookup_reg;
    assign stat.counted    = counted_reg;
    assign stat.slot_valid = rd_valid_reg;
    assign stat.key_match  = (rd_key_reg == key_reg);
    assign stat.last_probe = (32'(probe_reg) == MAX_PROBES - 1);
    assign stat.table_full = (used_reg >= FULL);

endmodule

// ===== rtl/kmer_edge_counter_top.sv =====
// channel  | ports                                             | handshake
// request  | kind first_of_read base_char query_kmer           | start & !busy
// result   | result_kind kmer_value edge_count newly_added ... | result_valid strobe
// config   | cfg_we cfg_idx cfg_data                           | cfg_we
// A base too early in its read gives no result. Other requests pass S_MUL_LO
// and S_MUL_HI, then S_READ and S_CHECK per probed slot (1 to MAX_PROBES) through
// the single table read port in the probe loop, then S_DONE.
// After reset, busy holds high while the slot valid bits are cleared
// one per cycle.
// The result strobe lasts one cycle and cannot be held off; busy falls after it.
module kmer_edge_counter_top
#(
    parameter int unsigned TABLE_ENTRIES = kec_pkg::TABLE_ENTRIES_DEF,
    parameter int unsigned MAX_PROBES    = kec_pkg::MAX_PROBES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        kind,
    input  logic        first_of_read,
    input  logic [7:0]  base_char,
    input  logic [63:0] query_kmer,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_idx,
    input  logic [15:0] cfg_data,
    output logic        result_valid,
    output logic        result_kind,
    output logic [63:0] kmer_value,
    output logic [31:0] edge_count,
    output logic        newly_added,
    output logic        meets_min_weight,
    output logic        table_overflow
);

    kec_pkg::kec_cmd_t  cmd;
    kec_pkg::kec_stat_t stat;
    logic               busy_int;

    kec_ctrl u_ctrl
    (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy_int),
        .stat(stat), .cmd(cmd)
    );

    kec_datapath #(.TABLE_ENTRIES(TABLE_ENTRIES), .MAX_PROBES(MAX_PROBES)) u_dp
    (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
        .kind(kind), .first_of_read(first_of_read), .base_char(base_char),
        .query_kmer(query_kmer), .result_valid(result_valid),
        .result_kind(result_kind), .kmer_value(kmer_value),
        .edge_count(edge_count), .newly_added(newly_added),
        .meets_min_weight(meets_min_weight), .table_overflow(table_overflow)
    );

    assign busy = busy_int;

endmodule

// ===== rtl/kec_checker.sv =====
module kec_checker
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic result_valid,
    input logic result_kind,
    input logic newly_added,
    input logic table_overflow,
    input logic [31:0] edge_count
);

    // a result only comes while a request is in flight
    a_res_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy) else $error("result while idle");

    // strobe is a single cycle
    a_res_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid) else $error("result held");

    // accepted request makes the block busy
    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("request dropped");

    a_lookup_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_kind) |-> (!newly_added && !table_overflow))
        else $error("lookup flags");

    a_new_one: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && newly_added) |-> (edge_count == 32'd1 && !table_overflow))
        else $error("new entry count");

endmodule

bind kmer_edge_counter_top kec_checker u_kec_checker
(
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .result_valid(result_valid), .result_kind(result_kind),
    .newly_added(newly_added), .table_overflow(table_overflow),
    .edge_count(edge_count)
);
